// File: src/gsp_pkg.sv
// shared types, constants and exponent tables for the gaussian sum potential block
`timescale 1ns / 1ps

package gsp_pkg;

    localparam int TERMS_DEF = 8;
    localparam int DIV_STEPS = 20;
    localparam int EXP_CUTOFF = 12;
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    localparam logic [2:0] REG_ACTIVE = 3'd0;
    localparam logic [2:0] REG_WLO_X  = 3'd1;
    localparam logic [2:0] REG_WHI_X  = 3'd2;
    localparam logic [2:0] REG_WLO_Y  = 3'd3;
    localparam logic [2:0] REG_WHI_Y  = 3'd4;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef struct packed {
        logic               action;
        logic [2:0]         term_index;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] amplitude;
        logic [15:0]        spread;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] energy;
        logic               outside_walls;
    } out_req_t;

    typedef struct packed {
        logic signed [15:0] amp;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [15:0]        sig;
    } term_t;

    // exp(-n) in q1.16
    function automatic logic [16:0] exp_int(input logic [3:0] n);
        logic [16:0] v;
        unique case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-k/16) in q1.16
    function automatic logic [16:0] exp_sixteenth(input logic [3:0] k);
        logic [16:0] v;
        unique case (k)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd61565;
            4'd2:  v = 17'd57836;
            4'd3:  v = 17'd54331;
            4'd4:  v = 17'd51039;
            4'd5:  v = 17'd47947;
            4'd6:  v = 17'd45042;
            4'd7:  v = 17'd42313;
            4'd8:  v = 17'd39750;
            4'd9:  v = 17'd37341;
            4'd10: v = 17'd35079;
            4'd11: v = 17'd32954;
            4'd12: v = 17'd30957;
            4'd13: v = 17'd29081;
            4'd14: v = 17'd27319;
            4'd15: v = 17'd25664;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/gsp_mul.sv
// shared signed 18x18 multiplier with registered product
`timescale 1ns / 1ps

module gsp_mul
(
    input  logic                clk,
    input  logic signed [17:0]  op_a,
    input  logic signed [17:0]  op_b,
    output logic signed [35:0]  prod
);

    logic signed [35:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// File: src/gsp_div.sv
// restoring divider, one quotient bit per cycle, for t = floor(sq * 2^16 / den)
`timescale 1ns / 1ps

module gsp_div
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [33:0]  sq,
    input  logic [33:0]  den,
    output logic         busy,
    output logic [19:0]  quot
);

    import gsp_pkg::*;

    logic [33:0] rem_reg, rem_next;
    logic [33:0] den_reg;
    logic [19:0] bits_reg, bits_next;
    logic [19:0] quot_reg, quot_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [34:0] shifted;
    logic [34:0] diff;

    // caller guarantees sq < 16 * den, so sq >> 4 starts below den
    always_comb
    begin
        shifted   = {rem_reg, bits_reg[19]};
        diff      = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        bits_next = bits_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            rem_next  = {4'd0, sq[33:4]};
            bits_next = {sq[3:0], 16'd0};
            quot_next = '0;
            cnt_next  = 5'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            bits_next = {bits_reg[18:0], 1'b0};
            cnt_next  = cnt_reg - 5'd1;
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next  = diff[33:0];
                quot_next = {quot_reg[18:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[33:0];
                quot_next = {quot_reg[18:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

endmodule

// File: src/gsp_table.sv
// term table memory, one write port and one registered read port
`timescale 1ns / 1ps

module gsp_table
#(
    parameter int TERMS = gsp_pkg::TERMS_DEF,
    parameter int IDX_W = (TERMS > 1) ? $clog2(TERMS) : 1
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  gsp_pkg::term_t       wdata,
    input  logic [IDX_W-1:0]     raddr,
    output gsp_pkg::term_t       rdata
);

    import gsp_pkg::*;

    term_t mem [TERMS];
    term_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/gaussian_sum_potential_core.sv
// top level: config registers, sequencer and datapath of the gaussian sum potential block
`timescale 1ns / 1ps

// usage
//   in channel: in_valid / in_stall / in_data. a load request writes one table
//   entry in the accepting cycle and gives no result. an evaluate request
//   gives one result on the out channel (out_valid / out_stall / out_data).
//   config: apb-style port, registers at byte address 4*i, written in the
//   access phase; pready is always high, reads return the register value.
// evaluate sequence
//   an evaluate checks the walls, then walks the active terms: per term
//   whose exponent is below 12 the shared 18x18 multiplier is used seven
//   times and the divider holds the sequencer while it runs. a term with
//   zero spread or an exponent of 16 or more does not wait on the divider;
//   one with an exponent of 12 to 15 waits and adds nothing. outside the
//   walls no term is summed. in_stall is high while an evaluate is in progress.
// reset
//   clears control state and config registers; the term table is not
//   cleared, so every entry must be loaded before it is summed.
// stall
//   the finished result sits in the output register; while out_stall holds
//   it, the block still takes new requests and the next evaluate waits at
//   its end until the register frees up.
module gaussian_sum_potential_core
#(
    parameter int TERMS = gsp_pkg::TERMS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  gsp_pkg::in_req_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output gsp_pkg::out_req_t             out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gsp_pkg::CFG_AW-1:0]    paddr,
    input  logic [gsp_pkg::CFG_DW-1:0]    pwdata,
    output logic [gsp_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready
);

    import gsp_pkg::*;

    localparam int IDX_W = (TERMS > 1) ? $clog2(TERMS) : 1;
    localparam int CNT_W = $clog2(TERMS + 1);

    typedef enum logic [15:0] {
        ST_IDLE  = 16'b0000_0000_0000_0001,
        ST_CHK   = 16'b0000_0000_0000_0010,
        ST_FETCH = 16'b0000_0000_0000_0100,
        ST_DX    = 16'b0000_0000_0000_1000,
        ST_DY    = 16'b0000_0000_0001_0000,
        ST_SG    = 16'b0000_0000_0010_0000,
        ST_DN    = 16'b0000_0000_0100_0000,
        ST_DIV   = 16'b0000_0000_1000_0000,
        ST_E1    = 16'b0000_0001_0000_0000,
        ST_E2    = 16'b0000_0010_0000_0000,
        ST_E3    = 16'b0000_0100_0000_0000,
        ST_E4    = 16'b0000_1000_0000_0000,
        ST_AMP   = 16'b0001_0000_0000_0000,
        ST_ACC   = 16'b0010_0000_0000_0000,
        ST_NEXT  = 16'b0100_0000_0000_0000,
        ST_DONE  = 16'b1000_0000_0000_0000
    } state_t;

    // config registers
    logic [3:0]         active_reg;
    logic signed [15:0] wlo_x_reg, whi_x_reg, wlo_y_reg, whi_y_reg;

    // sequencer and datapath registers
    state_t             state_reg, state_next;
    logic signed [15:0] qx_reg, qy_reg;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [33:0]        sq_reg, sq_next;
    logic [16:0]        e_reg, e_next;
    logic signed [31:0] sum_reg, sum_next;
    logic               outside_reg, outside_next;
    logic               out_valid_reg, out_valid_next;
    out_req_t           out_data_reg;

    // datapath signals
    logic               cfg_wr;
    logic               in_acc;
    logic               tbl_we;
    term_t              tbl_wdata;
    term_t              term;
    logic signed [17:0] op_a, op_b;
    logic signed [35:0] prod;
    logic signed [17:0] dx, dy;
    logic [33:0]        den;
    logic               div_start;
    logic               div_busy;
    logic [19:0]        t_q;
    logic [16:0]        poly;
    logic signed [27:0] contrib;
    logic               outside;
    logic [CNT_W-1:0]   count;
    logic               out_free;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            wlo_x_reg  <= 16'sh8000;
            whi_x_reg  <= 16'sh7fff;
            wlo_y_reg  <= 16'sh8000;
            whi_y_reg  <= 16'sh7fff;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_ACTIVE: active_reg <= pwdata[3:0];
                REG_WLO_X:  wlo_x_reg  <= pwdata[15:0];
                REG_WHI_X:  whi_x_reg  <= pwdata[15:0];
                REG_WLO_Y:  wlo_y_reg  <= pwdata[15:0];
                REG_WHI_Y:  whi_y_reg  <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_ACTIVE: prdata = {28'd0, active_reg};
            REG_WLO_X:  prdata = 32'(wlo_x_reg);
            REG_WHI_X:  prdata = 32'(whi_x_reg);
            REG_WLO_Y:  prdata = 32'(wlo_y_reg);
            REG_WHI_Y:  prdata = 32'(whi_y_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- request intake ----------------
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // loads go straight into the table; indexes past the table are dropped
    assign tbl_we        = in_acc && (in_data.action == ACT_LOAD)
                           && (32'(in_data.term_index) < TERMS);
    assign tbl_wdata.amp = in_data.amplitude;
    assign tbl_wdata.cx  = in_data.coord_x;
    assign tbl_wdata.cy  = in_data.coord_y;
    assign tbl_wdata.sig = in_data.spread;

    gsp_table #(
        .TERMS (TERMS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (IDX_W'(in_data.term_index)),
        .wdata (tbl_wdata),
        .raddr (j_reg[IDX_W-1:0]),
        .rdata (term)
    );

    // ---------------- shared multiplier ----------------
    assign dx = 18'(qx_reg) - 18'(term.cx);
    assign dy = 18'(qy_reg) - 18'(term.cy);

    // 1 - r + r^2/2 correction, r^2 arrives from the multiplier
    assign poly = 17'(18'd65536 - 18'(t_q[11:0]) + 18'(prod[23:17]));

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_DX:
            begin
                op_a = dx;
                op_b = dx;
            end
            ST_DY:
            begin
                op_a = dy;
                op_b = dy;
            end
            ST_SG:
            begin
                op_a = {2'b00, term.sig};
                op_b = {2'b00, term.sig};
            end
            ST_E1:
            begin
                op_a = {1'b0, exp_int(t_q[19:16])};
                op_b = {1'b0, exp_sixteenth(t_q[15:12])};
            end
            ST_E2:
            begin
                op_a = {6'd0, t_q[11:0]};
                op_b = {6'd0, t_q[11:0]};
            end
            ST_E3:
            begin
                op_a = {1'b0, e_reg};
                op_b = {1'b0, poly};
            end
            ST_AMP:
            begin
                op_a = 18'(term.amp);
                op_b = {1'b0, e_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    gsp_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // ---------------- divider ----------------
    assign den       = {prod[32:0], 1'b0};
    assign div_start = (state_reg == ST_DN);

    gsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sq    (sq_reg),
        .den   (den),
        .busy  (div_busy),
        .quot  (t_q)
    );

    // ---------------- sequencer ----------------
    assign outside = (qx_reg < wlo_x_reg) || (qx_reg > whi_x_reg)
                     || (qy_reg < wlo_y_reg) || (qy_reg > whi_y_reg);
    assign count   = (32'(active_reg) > TERMS) ? CNT_W'(TERMS) : CNT_W'(active_reg);
    assign contrib = prod[35:8];   // arithmetic shift is the floor
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        sq_next        = sq_reg;
        e_next         = e_reg;
        sum_next       = sum_reg;
        outside_next   = outside_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_data.action == ACT_EVAL))
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                j_next       = '0;
                cnt_next     = count;
                sum_next     = '0;
                outside_next = outside;
                if (outside)
                begin
                    sum_next   = 32'sh7fff_ffff;
                    state_next = ST_DONE;
                end
                else if (count == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_DX;
            ST_DX:    state_next = ST_DY;
            ST_DY:
            begin
                sq_next    = 34'(prod);
                state_next = ST_SG;
            end
            ST_SG:
            begin
                sq_next    = sq_reg + 34'(prod);
                state_next = ST_DN;
            end
            ST_DN:
            begin
                // zero spread or exponent of 16 or more adds nothing
                if ((den == '0) || ({4'd0, sq_reg} >= {den, 4'd0}))
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = (32'(t_q[19:16]) >= EXP_CUTOFF) ? ST_NEXT : ST_E1;
                end
            end
            ST_E1:    state_next = ST_E2;
            ST_E2:
            begin
                e_next     = prod[32:16];
                state_next = ST_E3;
            end
            ST_E3:    state_next = ST_E4;
            ST_E4:
            begin
                e_next     = prod[32:16];
                state_next = ST_AMP;
            end
            ST_AMP:   state_next = ST_ACC;
            ST_ACC:
            begin
                sum_next   = sum_reg + 32'(contrib);
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                j_next     = j_reg + CNT_W'(1);
                state_next = (j_reg + CNT_W'(1) == cnt_reg) ? ST_DONE : ST_FETCH;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            j_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            qx_reg <= in_data.coord_x;
            qy_reg <= in_data.coord_y;
        end
        sq_reg      <= sq_next;
        e_reg       <= e_next;
        sum_reg     <= sum_next;
        outside_reg <= outside_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_data_reg.energy        <= sum_reg;
            out_data_reg.outside_walls <= outside_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: tb/gsp_checker.sv
// checker for the gaussian sum potential block: predicts energies and compares results
`timescale 1ns / 1ps

module gsp_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  gsp_pkg::in_req_t            in_data,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  gsp_pkg::out_req_t           out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [gsp_pkg::CFG_AW-1:0]  paddr,
    input  logic [gsp_pkg::CFG_DW-1:0]  pwdata,
    output int                          fails,
    output int                          pending
);

    import gsp_pkg::*;

    logic [16:0] exp_whole [0:11] = '{
        17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442,
        17'd162, 17'd60, 17'd22, 17'd8, 17'd3, 17'd1
    };
    logic [16:0] exp_frac [0:15] = '{
        17'd65536, 17'd61565, 17'd57836, 17'd54331, 17'd51039, 17'd47947,
        17'd45042, 17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954,
        17'd30957, 17'd29081, 17'd27319, 17'd25664
    };

    term_t              terms [0:TERMS_DEF-1];
    logic [3:0]         n_active;
    logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
    out_req_t           energy_q [$];

    assign pending = energy_q.size();

    initial fails = 0;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    function automatic out_req_t predict_energy(input in_req_t q);
        out_req_t           res;
        longint             dx, dy, acc, amp_l, e_l;
        longint unsigned    sq, den, t, n, k, r, e, poly;
        int                 cnt;
        res.outside_walls = (q.coord_x < lo_x) || (q.coord_x > hi_x) ||
                            (q.coord_y < lo_y) || (q.coord_y > hi_y);
        if (res.outside_walls)
        begin
            res.energy = 32'sh7FFF_FFFF;
            return res;
        end
        cnt = (n_active > TERMS_DEF) ? TERMS_DEF : n_active;
        acc = 0;
        for (int j = 0; j < cnt; j++)
        begin
            dx = longint'(q.coord_x) - longint'(terms[j].cx);
            dy = longint'(q.coord_y) - longint'(terms[j].cy);
            sq = dx * dx + dy * dy;
            den = 2 * longint'(terms[j].sig) * longint'(terms[j].sig);
            if (den == 0)
                continue;
            t = (sq << 16) / den;
            n = t >> 16;
            if (n >= 12)
                continue;
            k = (t >> 12) & 15;
            r = t & 4095;
            e = (longint'(exp_whole[n]) * longint'(exp_frac[k])) >> 16;
            poly = 65536 - r + ((r * r) >> 17);
            e = (e * poly) >> 16;
            amp_l = longint'(terms[j].amp);
            e_l = e;
            // arithmetic shift floors toward minus infinity
            acc += (amp_l * e_l) >>> 8;
        end
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        res.energy = acc[31:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_req_t want;
        if (!rst_n)
        begin
            n_active <= '0;
            lo_x <= -16'sd32768;
            hi_x <= 16'sd32767;
            lo_y <= -16'sd32768;
            hi_y <= 16'sd32767;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_ACTIVE: n_active <= pwdata[3:0];
                    REG_WLO_X:  lo_x <= pwdata[15:0];
                    REG_WHI_X:  hi_x <= pwdata[15:0];
                    REG_WLO_Y:  lo_y <= pwdata[15:0];
                    REG_WHI_Y:  hi_y <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.action == ACT_LOAD)
                    terms[in_data.term_index] <= '{in_data.amplitude, in_data.coord_x,
                                                   in_data.coord_y, in_data.spread};
                else
                    energy_q.push_back(predict_energy(in_data));
            end
            if (out_valid && !out_stall)
            begin
                if (energy_q.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    want = energy_q.pop_front();
                    if (out_data.energy !== want.energy)
                        report($sformatf("energy %0d, expected %0d",
                                         out_data.energy, want.energy));
                    if (out_data.outside_walls !== want.outside_walls)
                        report($sformatf("outside_walls %0b, expected %0b",
                                         out_data.outside_walls, want.outside_walls));
                end
            end
        end
    end

endmodule

// File: tb/tb.sv
// testbench top: stimulus, config writes and verdict for the gaussian sum potential block
`timescale 1ns / 1ps

module tb;
    import gsp_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_req_t            in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_req_t           out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [CFG_AW-1:0]  paddr = '0;
    logic [CFG_DW-1:0]  pwdata = '0;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;
    int                 fails;
    int                 pending;

    // calm phases run with no gaps on either side
    bit                 calm = 1'b0;
    int                 out_hold = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    gaussian_sum_potential_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gsp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
    );

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    // receiver: after each accepted result hold stall for a drawn number of cycles
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            out_hold = draw_gap();
        else if (out_hold > 0)
            out_hold = out_hold - 1;
        out_stall <= (out_hold > 0);
    end

    // generous fixed limit, far above the slowest legal run
    initial
    begin
        #8_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // apb write of a setup and an access phase; the register takes the value at the access edge
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0000, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_walls(input logic [15:0] lx, input logic [15:0] hx,
                             input logic [15:0] ly, input logic [15:0] hy);
        cfg_write(REG_WLO_X, lx);
        cfg_write(REG_WHI_X, hx);
        cfg_write(REG_WLO_Y, ly);
        cfg_write(REG_WHI_Y, hy);
    endtask

    // drop valid, drain every expected result, then allow for a trailing evaluate
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // one request: optional gap, then hold until accepted
    task automatic send(input in_req_t req);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic in_req_t load_req(input logic [2:0] idx, input logic [15:0] x,
                                         input logic [15:0] y, input logic [15:0] amp,
                                         input logic [15:0] sig);
        in_req_t r;
        r = '{ACT_LOAD, idx, x, y, amp, sig};
        return r;
    endfunction

    function automatic in_req_t eval_req(input logic [15:0] x, input logic [15:0] y);
        in_req_t r;
        r = '{ACT_EVAL, 3'($urandom), x, y, 16'($urandom), 16'($urandom)};
        return r;
    endfunction

    // coordinate: mostly within 2048 of the origin, sometimes anywhere
    function automatic logic [15:0] pick_coord();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 4096) - 2048);
    endfunction

    function automatic in_req_t random_req();
        logic [15:0] sig;
        int          pick;
        if ($urandom_range(0, 9) < 3)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                sig = 16'd0;
            else if (pick < 4)
                sig = 16'($urandom);
            else
                sig = 16'($urandom_range(64, 1024));
            return load_req(3'($urandom), pick_coord(), pick_coord(), 16'($urandom), sig);
        end
        return eval_req(pick_coord(), pick_coord());
    endfunction

    initial
    begin
        logic [15:0] a, b;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table first so no evaluate ever reads an unwritten entry
        send(load_req(3'd0, 16'h0000, 16'h0000, 16'h0100, 16'd256));
        send(load_req(3'd1, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
        send(load_req(3'd2, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1));
        // zero spread entry
        send(load_req(3'd3, 16'h0200, 16'hFE00, 16'h7FFF, 16'd0));
        send(load_req(3'd4, 16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF));
        send(load_req(3'd5, 16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF));
        send(load_req(3'd6, 16'h0100, 16'h0000, 16'h8000, 16'd512));
        send(load_req(3'd7, 16'hFF00, 16'h0080, 16'h4000, 16'd128));
        // no active terms after reset
        send(eval_req(16'h0000, 16'h0000));
        settle();

        cfg_write(REG_ACTIVE, 16'd8);
        send(eval_req(16'h0000, 16'h0000));
        send(eval_req(16'h7FFF, 16'h7FFF));
        send(eval_req(16'h8000, 16'h8000));
        send(eval_req(16'h0100, 16'h0000));
        send(eval_req(16'h0400, 16'h0400));
        settle();

        // more active terms than the table holds
        cfg_write(REG_ACTIVE, 16'd15);
        send(eval_req(16'h0000, 16'h0000));
        settle();

        // inverted walls put everything outside
        set_walls(16'h0100, 16'hFF00, 16'h8000, 16'h7FFF);
        send(eval_req(16'h0000, 16'h0000));
        settle();

        // tight walls: inclusive edges inside, one step beyond outside
        set_walls(16'hFF00, 16'h0100, 16'hFF00, 16'h0100);
        send(eval_req(16'h0100, 16'h0100));
        send(eval_req(16'h0101, 16'h0000));
        send(eval_req(16'h0000, 16'hFEFF));
        send(eval_req(16'hFF00, 16'hFF00));
        settle();

        // random phases, each with a fresh setting of every register
        for (int p = 0; p < 12; p++)
        begin
            calm = (p % 3 == 2);
            case (p)
                0:       cfg_write(REG_ACTIVE, 16'd8);
                1:       cfg_write(REG_ACTIVE, 16'd15);
                2:       cfg_write(REG_ACTIVE, 16'd0);
                default: cfg_write(REG_ACTIVE, 16'($urandom_range(0, 15)));
            endcase
            if (p == 0 || p == 3)
                set_walls(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
            else if (p == 1)
                set_walls(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
            else
            begin
                case ($urandom_range(0, 3))
                    0: set_walls(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
                    1:
                    begin
                        a = 16'($urandom_range(0, 2048) - 2560);
                        b = 16'($urandom_range(0, 2048) + 512);
                        set_walls(a, b, 16'($urandom_range(0, 2048) - 2560),
                                  16'($urandom_range(0, 2048) + 512));
                    end
                    2: set_walls(16'h0200, 16'hFE00, 16'h8000, 16'h7FFF);
                    default: set_walls(16'($urandom), 16'($urandom),
                                       16'($urandom), 16'($urandom));
                endcase
            end
            repeat (152) send(random_req());
            settle();
        end

        if (fails == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
